/* rtl/core/dual_period_tachometer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dual period tachometer
// Shared property shorthands, clocked on clk with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef DUAL_PERIOD_TACHOMETER_ASSERT_SVH
`define DUAL_PERIOD_TACHOMETER_ASSERT_SVH

// same-cycle implication
`define DPT_ASSERT_NOW(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dual_period_tachometer: same-cycle property violated");

// next-cycle implication
`define DPT_ASSERT_NEXT(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dual_period_tachometer: next-cycle property violated");

`endif

/* rtl/core/dpt_pkg.sv */
// ---------------------------------------------------------------------------
// dpt_pkg
// Types and constants shared by the dual period tachometer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

	localparam int NUM_W       = 33;  // speed dividend width
	localparam int PULSE_W     = 8;   // pulses per revolution width
	localparam int STAMP_IN_W  = 32;  // timestamp field width
	localparam int CMD_W       = 8;   // host command width
	localparam int OUT_W       = 15;  // reported speed width
	localparam int QUEUE_DEPTH = 2;   // tick snapshots between front and back

	localparam int DEFAULT_STAMP_WIDTH = 32;
	localparam int DEFAULT_SPEED_WIDTH = 16;

	localparam logic [NUM_W-1:0]   DEFAULT_NUMERATOR = 33'd4320000000; // 72 MHz * 60
	localparam logic [PULSE_W-1:0] DEFAULT_PULSES    = 8'd42;

	localparam logic [CMD_W-1:0] CMD_STOP = 8'h80;
	localparam logic [CMD_W-1:0] CMD_RUN  = 8'h81;

	typedef enum logic [1:0] {
		OP_SENSOR = 2'd0,
		OP_TICK   = 2'd1,
		OP_BUTTON = 2'd2,
		OP_HOST   = 2'd3
	} dpt_op_t;

	typedef enum logic [0:0] {
		REG_NUMERATOR = 1'b0,
		REG_PULSES    = 1'b1
	} dpt_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SETUP,
		BK_DIV_W,
		BK_DIV_P,
		BK_EMIT
	} dpt_back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dpt_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/dpt_queue.sv */
// ---------------------------------------------------------------------------
// dpt_queue
// Short FIFO of window snapshots between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module dpt_queue
	import dpt_pkg::*;
#(
	parameter int WIDTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output dpt_qstat_t            qstat,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign qstat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dpt_front.sv */
// ---------------------------------------------------------------------------
// dpt_front
// Takes one item per cycle while the queue is not full: sensor edges, ticks, button and host commands.
// ---------------------------------------------------------------------------
`default_nettype none

module dpt_front
	import dpt_pkg::*;
#(
	parameter int STAMP_WIDTH = DEFAULT_STAMP_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               op,
	input  wire logic                     channel,
	input  wire logic                     level_high,
	input  wire logic [STAMP_IN_W-1:0]    timestamp,
	input  wire logic [CMD_W-1:0]         command_byte,
	input  wire dpt_qstat_t               qstat,
	output logic                          push,
	output logic [2*STAMP_WIDTH-1:0]      push_data
);

	localparam int COPY_W = (STAMP_WIDTH < STAMP_IN_W) ? STAMP_WIDTH : STAMP_IN_W;

	logic                   running_q;
	logic [1:0]             armed_q;
	logic [STAMP_WIDTH-1:0] start_q [2];
	logic [STAMP_WIDTH-1:0] win_q   [2];

	dpt_op_t                op_code;
	logic                   accept;
	logic [STAMP_WIDTH-1:0] stamp;
	logic [STAMP_WIDTH-1:0] span;

	assign op_code   = dpt_op_t'(op);
	assign in_ready  = !qstat.full;
	assign accept    = in_valid && in_ready;
	assign stamp     = STAMP_WIDTH'(timestamp[COPY_W-1:0]);
	assign span      = stamp - start_q[channel];  // wraps modulo 2^STAMP_WIDTH
	assign push      = accept && (op_code == OP_TICK) && running_q;
	assign push_data = {win_q[1], win_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			armed_q   <= '0;
			start_q   <= '{default: '0};
			win_q     <= '{default: '0};
		end else if (accept) begin
			unique case (op_code)
				OP_SENSOR: begin
					if (level_high) begin
						if (!armed_q[channel]) begin
							start_q[channel] <= stamp;
							armed_q[channel] <= 1'b1;
						end else begin
							armed_q[channel] <= 1'b0;
							// first closed interval only marks the window
							if (win_q[channel] == '0) begin
								win_q[channel] <= STAMP_WIDTH'(1);
							end else if (span > win_q[channel]) begin
								win_q[channel] <= span;
							end
						end
					end
				end
				OP_TICK: begin
					if (running_q) begin
						win_q <= '{default: '0};
					end
				end
				OP_BUTTON: begin
					if (level_high) begin
						running_q <= !running_q;
					end
				end
				OP_HOST: begin
					if (command_byte == CMD_STOP) begin
						running_q <= 1'b0;
					end else if (command_byte == CMD_RUN) begin
						running_q <= 1'b1;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dpt_back.sv */
// ---------------------------------------------------------------------------
// dpt_back
// Turns a window snapshot into two speeds with a shared radix-2 divider.
// ---------------------------------------------------------------------------
`default_nettype none

module dpt_back
	import dpt_pkg::*;
#(
	parameter int STAMP_WIDTH = DEFAULT_STAMP_WIDTH,
	parameter int SPEED_WIDTH = DEFAULT_SPEED_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dpt_qstat_t               qstat,
	input  wire logic [2*STAMP_WIDTH-1:0] q_data,
	output logic                          pop,
	input  wire logic [NUM_W-1:0]         rpm_numerator,
	input  wire logic [PULSE_W-1:0]       pulses_per_rev,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [OUT_W-1:0]              left_rpm,
	output logic [OUT_W-1:0]              right_rpm
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [NUM_W-1:0] SPEED_MAX =
		NUM_W'((64'd1 << (SPEED_WIDTH - 1)) - 64'd1);

	dpt_back_state_t state_q, state_d;

	logic                   ch_q;
	logic [NUM_W-1:0]       dividend_q;  // dividend in, quotient shifts in from the bottom
	logic [STAMP_WIDTH-1:0] divisor_q;
	logic [STAMP_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [OUT_W-1:0]       left_q;
	logic [OUT_W-1:0]       right_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_left_q;
	logic [OUT_W-1:0]       out_right_q;

	logic [STAMP_WIDTH-1:0] win_sel;
	logic                   win_small;
	logic                   p_zero;
	logic [STAMP_WIDTH:0]   trial;
	logic [STAMP_WIDTH:0]   diff;
	logic                   ge;
	logic [STAMP_WIDTH-1:0] rem_next;
	logic [NUM_W-1:0]       quo;
	logic                   last_step;
	logic [OUT_W-1:0]       speed;
	logic                   out_free;

	logic                   start_div_w;
	logic                   start_div_p;
	logic                   div_step;
	logic                   store_res;
	logic [OUT_W-1:0]       res_val;
	logic                   load_out;

	assign win_sel   = ch_q ? q_data[2*STAMP_WIDTH-1:STAMP_WIDTH] : q_data[STAMP_WIDTH-1:0];
	assign win_small = (win_sel[STAMP_WIDTH-1:1] == '0);
	assign p_zero    = (pulses_per_rev == '0);

	// one restoring step
	assign trial     = {rem_q, dividend_q[NUM_W-1]};
	assign diff      = trial - {1'b0, divisor_q};
	assign ge        = (trial >= {1'b0, divisor_q});
	assign rem_next  = ge ? diff[STAMP_WIDTH-1:0] : trial[STAMP_WIDTH-1:0];
	assign quo       = {dividend_q[NUM_W-2:0], ge};
	assign last_step = (cnt_q == CNT_W'(NUM_W - 1));
	assign speed     = (quo > SPEED_MAX) ? SPEED_MAX[OUT_W-1:0] : quo[OUT_W-1:0];
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					state_d = BK_SETUP;
				end
			end
			BK_SETUP: begin
				if (win_small || p_zero) begin
					state_d = ch_q ? BK_EMIT : BK_SETUP;
				end else begin
					state_d = BK_DIV_W;
				end
			end
			BK_DIV_W: begin
				if (last_step) begin
					state_d = BK_DIV_P;
				end
			end
			BK_DIV_P: begin
				if (last_step) begin
					state_d = ch_q ? BK_EMIT : BK_SETUP;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		start_div_w = 1'b0;
		start_div_p = 1'b0;
		div_step    = 1'b0;
		store_res   = 1'b0;
		res_val     = speed;
		load_out    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
			end
			BK_SETUP: begin
				if (win_small || p_zero) begin
					store_res = 1'b1;
					res_val   = win_small ? '0 : SPEED_MAX[OUT_W-1:0];
				end else begin
					start_div_w = 1'b1;
				end
			end
			BK_DIV_W: begin
				div_step    = 1'b1;
				start_div_p = last_step;
			end
			BK_DIV_P: begin
				div_step  = 1'b1;
				store_res = last_step;
			end
			BK_EMIT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	assign pop = load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (store_res) begin
				ch_q <= !ch_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_div_w) begin
			dividend_q <= rpm_numerator;
			divisor_q  <= win_sel;
			rem_q      <= '0;
			cnt_q      <= '0;
		end else if (start_div_p) begin
			// second pass: floor(n / w) / p
			dividend_q <= quo;
			divisor_q  <= STAMP_WIDTH'(pulses_per_rev);
			rem_q      <= '0;
			cnt_q      <= '0;
		end else if (div_step) begin
			dividend_q <= quo;
			rem_q      <= rem_next;
			cnt_q      <= cnt_q + CNT_W'(1);
		end
		if (store_res) begin
			if (ch_q) begin
				right_q <= res_val;
			end else begin
				left_q <= res_val;
			end
		end
		if (load_out) begin
			out_left_q  <= left_q;
			out_right_q <= right_q;
		end
	end

	assign out_valid = out_valid_q;
	assign left_rpm  = out_left_q;
	assign right_rpm = out_right_q;

endmodule

`default_nettype wire

/* rtl/core/dual_period_tachometer.sv */
// ---------------------------------------------------------------------------
// dual_period_tachometer
// Two-channel period tachometer with run/stop control and speed reports.
// ---------------------------------------------------------------------------
//  channel   dir  handshake               content
//  s_axis    in   tvalid/tready           sensor edge, tick, button, host byte
//  m_axis    out  tvalid/tready           left and right speed per tick
//  cfg       in   cfg_valid/cfg_ready     register index and write data
//
//  The front takes one input transaction per cycle, any op, while tready is high.
//  A tick while running leaves a window snapshot in a two-entry queue; the
//  back divides it through one radix-2 divider, two quotients per channel
//  when the window divides: numerator by window, then by pulses per rev.
//  A result waits while the result register is held.
//  tready drops only while both queue entries hold unreported ticks.
//  cfg_ready is always high. Reset (arst_n low) stops the block, clears the
//  windows and loads the default register values.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_period_tachometer
	import dpt_pkg::*;
#(
	parameter int STAMP_WIDTH = DEFAULT_STAMP_WIDTH,
	parameter int SPEED_WIDTH = DEFAULT_SPEED_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // level_high[0], timestamp[32:1],
	                                         // command_byte[40:33], zero[47:41]
	input  wire logic [2:0]  s_axis_tuser,   // op[1:0], channel[2]
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // left_rpm[14:0], right_rpm[29:15], zero[31:30]
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [32:0] cfg_data
);

	localparam int SNAP_W = 2 * STAMP_WIDTH;

	logic [NUM_W-1:0]   numerator_q;
	logic [PULSE_W-1:0] pulses_q;

	dpt_qstat_t         qstat;
	logic               push;
	logic [SNAP_W-1:0]  push_data;
	logic               pop;
	logic [SNAP_W-1:0]  pop_data;
	logic [OUT_W-1:0]   left_rpm;
	logic [OUT_W-1:0]   right_rpm;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q <= DEFAULT_NUMERATOR;
			pulses_q    <= DEFAULT_PULSES;
		end else if (cfg_valid) begin
			unique case (dpt_reg_t'(cfg_index))
				REG_NUMERATOR: numerator_q <= cfg_data;
				REG_PULSES:    pulses_q    <= cfg_data[PULSE_W-1:0];
			endcase
		end
	end

	// front: edge capture, window tracking, run state
	dpt_front #(
		.STAMP_WIDTH(STAMP_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.op          (s_axis_tuser[1:0]),
		.channel     (s_axis_tuser[2]),
		.level_high  (s_axis_tdata[0]),
		.timestamp   (s_axis_tdata[32:1]),
		.command_byte(s_axis_tdata[40:33]),
		.qstat       (qstat),
		.push        (push),
		.push_data   (push_data)
	);

	// snapshots waiting for the divider
	dpt_queue #(
		.WIDTH(SNAP_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.qstat    (qstat),
		.pop_data (pop_data)
	);

	// back: speed = numerator / window / pulses, saturated
	dpt_back #(
		.STAMP_WIDTH(STAMP_WIDTH),
		.SPEED_WIDTH(SPEED_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.q_data        (pop_data),
		.pop           (pop),
		.rpm_numerator (numerator_q),
		.pulses_per_rev(pulses_q),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.left_rpm      (left_rpm),
		.right_rpm     (right_rpm)
	);

	assign m_axis_tdata = {2'b00, right_rpm, left_rpm};

endmodule

`default_nettype wire

/* rtl/core/dpt_checker.sv */
// ---------------------------------------------------------------------------
// dpt_checker
// Port-level checks on the tachometer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_period_tachometer_assert.svh"

module dpt_checker
	import dpt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic [2:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	logic       run_q;
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;
	dpt_op_t    op_code;
	logic       tick_counts;

	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign out_acc     = m_axis_tvalid && m_axis_tready;
	assign op_code     = dpt_op_t'(s_axis_tuser[1:0]);
	assign tick_counts = in_acc && (op_code == OP_TICK) && run_q;

	// shadow of the run state and of ticks still owed a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			pend_q <= '0;
		end else begin
			if (in_acc && (op_code == OP_BUTTON) && s_axis_tdata[0]) begin
				run_q <= !run_q;
			end else if (in_acc && (op_code == OP_HOST) && (s_axis_tdata[40:33] == CMD_STOP)) begin
				run_q <= 1'b0;
			end else if (in_acc && (op_code == OP_HOST) && (s_axis_tdata[40:33] == CMD_RUN)) begin
				run_q <= 1'b1;
			end
			if (tick_counts && !out_acc) begin
				pend_q <= pend_q + 3'd1;
			end else if (out_acc && !tick_counts) begin
				pend_q <= pend_q - 3'd1;
			end
		end
	end

	`DPT_ASSERT_NOW(a_result_needs_tick, arst_n, m_axis_tvalid, pend_q != 3'd0)
	`DPT_ASSERT_NOW(a_stall_needs_backlog, arst_n, !s_axis_tready, pend_q >= 3'(QUEUE_DEPTH))
	`DPT_ASSERT_NEXT(a_out_valid_holds, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`DPT_ASSERT_NEXT(a_out_data_holds, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind dual_period_tachometer dpt_checker u_dpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

/* tb/dual_period_tachometer_tb.sv */
// ---------------------------------------------------------------------------
// dual_period_tachometer_tb
// Self-checking bench for the two-channel period tachometer. Items go into
// the input stream with random gaps. A model inside the bench tracks the
// run state, the armed flags and the longest window per channel, and queues
// the speed pair that each running tick should report. The result stream is
// checked against that queue, with random back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_period_tachometer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dpt_pkg::*;

	localparam int DRAIN_CYCLES = 200;  // quiet time after the last owed result
	localparam int SPEED_MAX    = (1 << (DEFAULT_SPEED_WIDTH - 1)) - 1;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata  = '0;
	logic [2:0]        s_axis_tuser  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [31:0]       m_axis_tdata;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_index     = '0;
	logic [NUM_W-1:0]  cfg_data      = '0;

	always #5 clk = ~clk;

	dual_period_tachometer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// one speed report: left in the low bits, as on the result stream
	typedef struct packed {
		logic [OUT_W-1:0] right;
		logic [OUT_W-1:0] left;
	} rpm_pair_t;

	// -- model state --------------------------------------------------------
	logic [NUM_W-1:0]      numer_cfg  = DEFAULT_NUMERATOR;
	logic [PULSE_W-1:0]    pulses_cfg = DEFAULT_PULSES;
	logic                  run_state  = 1'b0;
	logic                  armed_ch  [2] = '{1'b0, 1'b0};
	logic [STAMP_IN_W-1:0] arm_stamp [2] = '{'0, '0};
	logic [STAMP_IN_W-1:0] span_max  [2] = '{'0, '0};

	rpm_pair_t rpm_expected [$];   // speed pairs owed by the block, oldest first
	rpm_pair_t rpm_wanted;
	int        mismatch_count = 0;
	logic      no_idle = 1'b0;     // both sides stream without gaps while set

	// sensor pin clocks for well-formed random traffic
	logic [STAMP_IN_W-1:0] pin_time [2];

	// -- speed of one window ------------------------------------------------
	// Windows of 0 or 1 are empty or discarded: speed 0. Zero pulses per rev
	// means a zero divisor, which reads as full scale.
	function automatic logic [OUT_W-1:0] rpm_of(logic [STAMP_IN_W-1:0] window);
		logic [NUM_W-1:0] per_window;
		logic [NUM_W-1:0] q;
		if (window <= 1)
			return '0;
		if (pulses_cfg == '0)
			return SPEED_MAX[OUT_W-1:0];
		// floor(floor(n / w) / p) == floor(n / (w * p))
		per_window = numer_cfg / NUM_W'(window);
		q = per_window / NUM_W'(pulses_cfg);
		if (q > SPEED_MAX)
			q = NUM_W'(SPEED_MAX);
		return q[OUT_W-1:0];
	endfunction

	// -- model update for one accepted input transaction --------------------
	task automatic track_item(dpt_op_t op, logic ch, logic level,
		logic [STAMP_IN_W-1:0] stamp, logic [CMD_W-1:0] cmd);
		rpm_pair_t             pair;
		logic [STAMP_IN_W-1:0] span;
		case (op)
		OP_SENSOR: begin
			if (level) begin
				if (!armed_ch[ch]) begin
					arm_stamp[ch] = stamp;
					armed_ch[ch]  = 1'b1;
				end else begin
					armed_ch[ch] = 1'b0;
					span = stamp - arm_stamp[ch];   // wraps mod 2^32
					if (span_max[ch] == '0)
						span_max[ch] = STAMP_IN_W'(1); // first interval only marks the window
					else if (span > span_max[ch])
						span_max[ch] = span;
				end
			end
		end
		OP_TICK: begin
			// stopped: no report, windows kept
			if (run_state) begin
				pair.left  = rpm_of(span_max[0]);
				pair.right = rpm_of(span_max[1]);
				rpm_expected.push_back(pair);
				span_max[0] = '0;
				span_max[1] = '0;
			end
		end
		OP_BUTTON: begin
			if (level)
				run_state = !run_state;
		end
		OP_HOST: begin
			if (cmd == CMD_STOP)
				run_state = 1'b0;
			else if (cmd == CMD_RUN)
				run_state = 1'b1;
		end
		endcase
	endtask

	// -- input stream driver ------------------------------------------------
	// Leaves tvalid high on return so the next item can follow back to back;
	// anything that lets time pass without a new item must lower it first.
	task automatic send_item(dpt_op_t op, logic ch, logic level,
		logic [STAMP_IN_W-1:0] stamp, logic [CMD_W-1:0] cmd);
		while (!no_idle && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, cmd, stamp, level};
		s_axis_tuser  <= {ch, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		track_item(op, ch, level, stamp, cmd);
	endtask

	task automatic sensor(logic ch, logic [STAMP_IN_W-1:0] stamp);
		send_item(OP_SENSOR, ch, 1'b1, stamp, CMD_W'($urandom()));
	endtask

	task automatic tick_item();
		send_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
			CMD_W'($urandom()));
	endtask

	task automatic button(logic level);
		send_item(OP_BUTTON, 1'($urandom_range(1)), level, $urandom(), CMD_W'($urandom()));
	endtask

	task automatic host(logic [CMD_W-1:0] cmd);
		send_item(OP_HOST, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(), cmd);
	endtask

	// stop feeding, collect every owed result, then let the back end go quiet
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (rpm_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// both registers, back to back, only once the block is idle
	task automatic write_regs(logic [NUM_W-1:0] numer, logic [PULSE_W-1:0] pulses);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= REG_NUMERATOR;
		cfg_data  <= numer;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		numer_cfg = numer;
		cfg_index <= REG_PULSES;
		cfg_data  <= NUM_W'(pulses);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pulses_cfg = pulses;
		cfg_valid <= 1'b0;
	endtask

	// -- random traffic -----------------------------------------------------
	// Mostly sensor edges on advancing pin clocks, so arm/close pairs form
	// real intervals; ticks, run/stop control and stray edges mixed in.
	task automatic random_traffic(int n);
		int unsigned           pick;
		int unsigned           sel;
		logic                  ch;
		logic [STAMP_IN_W-1:0] span;
		logic [CMD_W-1:0]      cmd;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			ch   = 1'($urandom_range(1));
			if (pick < 62) begin
				case ($urandom_range(2))
				0:       span = $urandom_range(15);              // saturating speeds
				1:       span = $urandom_range(1 << 20, 1 << 10);
				default: span = $urandom();                      // slow, often wraps
				endcase
				pin_time[ch] += span;
				send_item(OP_SENSOR, ch, $urandom_range(19) != 0, pin_time[ch],
					CMD_W'($urandom()));
			end else if (pick < 72) begin
				tick_item();
			end else if (pick < 76) begin
				button(1'($urandom_range(1)));
			end else if (pick < 92) begin
				sel = $urandom_range(99);
				if (sel < 70)
					cmd = CMD_RUN;
				else if (sel < 85)
					cmd = CMD_STOP;
				else
					cmd = CMD_W'($urandom());
				host(cmd);
			end else begin
				// stray edge at an unrelated time stamp
				send_item(OP_SENSOR, ch, 1'($urandom_range(1)), $urandom(),
					CMD_W'($urandom()));
			end
		end
	endtask

	// -- tests --------------------------------------------------------------
	// Reset defaults: 4320000000 / (w * 42). Covers ignored host bytes,
	// ticks while stopped, button levels, discarded first interval, wrap,
	// longest-window hold, low-level edges, saturation, edges while stopped.
	task automatic test_defaults_and_special_cases();
		host(8'hFF);                      // not a command: ignored
		tick_item();                      // stopped: no report
		button(1'b0);                     // press: nothing
		button(1'b1);                     // release: run
		tick_item();                      // empty windows: 0, 0
		sensor(1'b0, 32'hFFFF_FFF0);
		sensor(1'b0, 32'h0000_0010);      // first interval: window marked 1
		sensor(1'b0, 32'hFFFF_0000);
		sensor(1'b0, 32'h0000_1000);      // wrapped span 0x11000
		sensor(1'b0, 32'h8000_0000);
		sensor(1'b0, 32'h8001_86A0);      // 100000: new longest
		send_item(OP_SENSOR, 1'b0, 1'b0, 32'h8002_0000, 8'h00);  // falling: nothing
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_01F4);      // shorter: kept at 100000
		tick_item();
		host(CMD_STOP);
		sensor(1'b1, 32'h0000_0000);      // edges still count while stopped
		sensor(1'b1, 32'h0000_0000);
		sensor(1'b1, 32'h0000_0010);
		sensor(1'b1, 32'h0000_0015);      // window 5: saturates
		tick_item();                      // stopped: windows kept
		host(CMD_RUN);
		tick_item();
		button(1'b1);                     // stop
		button(1'b1);                     // run again
	endtask

	// register extremes, including the zero divisor
	task automatic test_register_extremes();
		write_regs('1, 8'd255);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'hFFFF_FFFF);      // longest possible window
		sensor(1'b1, 32'h0000_0000);
		sensor(1'b1, 32'h0000_0000);
		sensor(1'b1, 32'h0000_0000);
		sensor(1'b1, 32'h0000_0002);
		tick_item();
		write_regs(NUM_W'(1), 8'd1);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0002);
		tick_item();
		write_regs({1'($urandom_range(1)), 32'($urandom()) | 32'd1}, 8'd0);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0000);
		sensor(1'b0, 32'h0000_0007);      // zero divisor: full scale
		sensor(1'b1, 32'h0000_0000);
		sensor(1'b1, 32'h0000_0000);      // window 1: still 0
		tick_item();
	endtask

	task automatic test_mixed_traffic(logic [NUM_W-1:0] numer, logic [PULSE_W-1:0] pulses,
		int n);
		write_regs(numer, pulses);
		random_traffic(n);
	endtask

	// same traffic with no gaps on either side
	task automatic test_back_to_back(int n);
		drain_results();
		no_idle = 1'b1;
		test_mixed_traffic({1'($urandom_range(1)), 32'($urandom()) | 32'd1},
			PULSE_W'($urandom_range(255, 1)), n);
		drain_results();
		no_idle = 1'b0;
	endtask

	// -- result checker -----------------------------------------------------
	function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rpm_expected.size() == 0) begin
				note_mismatch("unexpected result transaction", 0, 32'(m_axis_tdata[29:0]));
			end else begin
				rpm_wanted = rpm_expected.pop_front();
				if (m_axis_tdata[14:0] != rpm_wanted.left)
					note_mismatch("left_rpm", 32'(rpm_wanted.left), 32'(m_axis_tdata[14:0]));
				if (m_axis_tdata[29:15] != rpm_wanted.right)
					note_mismatch("right_rpm", 32'(rpm_wanted.right),
						32'(m_axis_tdata[29:15]));
			end
		end
	end

	// result-side back-pressure
	always @(posedge clk)
		m_axis_tready <= no_idle || ($urandom_range(99) >= 35);

	// -- sequence -----------------------------------------------------------
	initial begin
		pin_time[0] = $urandom();
		pin_time[1] = $urandom();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_and_special_cases();
		test_register_extremes();
		test_mixed_traffic(DEFAULT_NUMERATOR, DEFAULT_PULSES, 400);
		test_back_to_back(350);
		test_mixed_traffic('1, 8'd255, 300);
		test_mixed_traffic(NUM_W'(1), 8'd1, 150);
		test_mixed_traffic({1'($urandom_range(1)), 32'($urandom()) | 32'd1},
			PULSE_W'($urandom_range(255, 1)), 300);
		test_mixed_traffic({1'($urandom_range(1)), 32'($urandom()) | 32'd1}, 8'd0, 100);

		drain_results();
		if (mismatch_count == 0 && rpm_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// hung handshake guard
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
